FILE: hw/rtl/status_frame_deframer_core_macros.svh
// Assertion macros of the status frame deframer, used by sfd_ctrl.
`ifndef STATUS_FRAME_DEFRAMER_CORE_MACROS_SVH
`define STATUS_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("status frame deframer check failed");

// Next-cycle implication, checked outside reset.
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("status frame deframer check failed");

`endif

FILE: hw/rtl/sfd_pkg.sv
// Package with constants and types of the status frame deframer.
`default_nettype none
package sfd_pkg;
  localparam int PAYLOAD_BYTES = 40;
  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int BYTE_W = 8;
  localparam int IDX_W = 6;

  localparam logic [BYTE_W-1:0] HDR_FIRST = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h00;
  localparam logic [BYTE_W-1:0] TRL_FIRST = 8'h00;
  localparam logic [BYTE_W-1:0] TRL_SECOND = 8'hAA;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HDR2,
    PH_DATA,
    PH_TRL1,
    PH_TRL2,
    PH_EMIT
  } phase_t;

  typedef struct packed {
    logic shift;
    logic [BYTE_W-1:0] tail_data;
  } chain_ctrl_t;
endpackage
`default_nettype wire

FILE: hw/rtl/sfd_in_if.sv
// Input channel interface carrying one received byte per word.
`default_nettype none
interface sfd_in_if;
  logic valid;
  logic ready;
  logic [sfd_pkg::BYTE_W-1:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sfd_out_if.sv
// Output channel interface carrying one payload byte with its index per word.
`default_nettype none
interface sfd_out_if;
  logic valid;
  logic ready;
  logic [sfd_pkg::BYTE_W-1:0] payload_byte;
  logic [sfd_pkg::IDX_W-1:0] byte_index;
  logic last;

  modport source(output valid, output payload_byte, output byte_index, output last,
                 input ready);
  modport sink(input valid, input payload_byte, input byte_index, input last,
               output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/status_frame_deframer_core.sv
// Top level of the status frame deframer: control plus the payload cell chain.
//
//   Port  Direction  Word contents
//   rx    sink       rx_byte
//   tx    source     payload_byte, byte_index, last
//
// Every received byte is taken as soon as it is valid while no frame is being sent.
// An accepted frame is sent as PAYLOAD_BYTES words, one per cycle when tx is
// ready; rx stays not ready until its last word is taken.
// Payload bytes shift through a chain of PAYLOAD_BYTES cells, in while
// collecting and out while sending. Reset (rst, synchronous) returns the
// block to hunting for a header.
`default_nettype none
module status_frame_deframer_core (
  input  wire logic clk,
  input  wire logic rst,
  sfd_in_if.sink    rx,
  sfd_out_if.source tx
);
  sfd_pkg::chain_ctrl_t ctrl;
  logic [sfd_pkg::BYTE_W-1:0] cell_data [sfd_pkg::PAYLOAD_BYTES];

  sfd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_byte    (rx.rx_byte),
    .in_ready   (rx.ready),
    .out_valid  (tx.valid),
    .out_ready  (tx.ready),
    .byte_index (tx.byte_index),
    .last       (tx.last),
    .ctrl       (ctrl)
  );

  for (genvar i = 0; i < sfd_pkg::PAYLOAD_BYTES; i++) begin : g_cell
    if (i == sfd_pkg::PAYLOAD_BYTES - 1) begin : g_tail
      sfd_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .neighbor (ctrl.tail_data),
        .data     (cell_data[i])
      );
    end else begin : g_body
      sfd_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .neighbor (cell_data[i+1]),
        .data     (cell_data[i])
      );
    end
  end

  assign tx.payload_byte = cell_data[0];
endmodule
`default_nettype wire

FILE: hw/rtl/sfd_cell.sv
// One storage cell of the payload shift chain.
`default_nettype none
module sfd_cell (
  input  wire logic clk,
  input  wire sfd_pkg::chain_ctrl_t ctrl,
  input  wire logic [sfd_pkg::BYTE_W-1:0] neighbor,
  output logic [sfd_pkg::BYTE_W-1:0] data
);
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= neighbor;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/sfd_ctrl.sv
// Frame state machine and handshake control of the status frame deframer.
`default_nettype none
`include "status_frame_deframer_core_macros.svh"
module sfd_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [sfd_pkg::BYTE_W-1:0] in_byte,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [sfd_pkg::IDX_W-1:0] byte_index,
  output logic last,
  output sfd_pkg::chain_ctrl_t ctrl
);
  localparam logic [sfd_pkg::CNT_W-1:0] LAST_IDX = sfd_pkg::CNT_W'(sfd_pkg::PAYLOAD_BYTES - 1);

  sfd_pkg::phase_t state;
  sfd_pkg::phase_t state_next;
  logic [sfd_pkg::CNT_W-1:0] fill_count;
  logic [sfd_pkg::CNT_W-1:0] fill_count_next;
  logic [sfd_pkg::CNT_W-1:0] emit_idx;
  logic [sfd_pkg::CNT_W-1:0] emit_idx_next;
  logic in_acc;
  logic out_acc;

  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    state_next = state;
    case (state)
      sfd_pkg::PH_HUNT: begin
        if (in_acc && in_byte == sfd_pkg::HDR_FIRST) state_next = sfd_pkg::PH_HDR2;
      end
      sfd_pkg::PH_HDR2: begin
        if (in_acc) begin
          state_next = (in_byte == sfd_pkg::HDR_SECOND) ? sfd_pkg::PH_DATA : sfd_pkg::PH_HUNT;
        end
      end
      sfd_pkg::PH_DATA: begin
        if (in_acc && fill_count == LAST_IDX) state_next = sfd_pkg::PH_TRL1;
      end
      sfd_pkg::PH_TRL1: begin
        if (in_acc) begin
          state_next = (in_byte == sfd_pkg::TRL_FIRST) ? sfd_pkg::PH_TRL2 : sfd_pkg::PH_HUNT;
        end
      end
      sfd_pkg::PH_TRL2: begin
        if (in_acc) begin
          state_next = (in_byte == sfd_pkg::TRL_SECOND) ? sfd_pkg::PH_EMIT : sfd_pkg::PH_HUNT;
        end
      end
      sfd_pkg::PH_EMIT: begin
        if (out_acc && emit_idx == LAST_IDX) state_next = sfd_pkg::PH_HUNT;
      end
      default: state_next = sfd_pkg::PH_HUNT;
    endcase
  end

  always_comb begin
    fill_count_next = '0;
    emit_idx_next = '0;
    if (state == sfd_pkg::PH_DATA) begin
      fill_count_next = fill_count;
      if (in_acc) fill_count_next = (fill_count == LAST_IDX) ? '0 : fill_count + 1'b1;
    end
    if (state == sfd_pkg::PH_EMIT) begin
      emit_idx_next = emit_idx;
      if (out_acc) emit_idx_next = (emit_idx == LAST_IDX) ? '0 : emit_idx + 1'b1;
    end
  end

  always_comb begin
    in_ready = (state != sfd_pkg::PH_EMIT);
    out_valid = (state == sfd_pkg::PH_EMIT);
    byte_index = sfd_pkg::IDX_W'(emit_idx);
    last = (emit_idx == LAST_IDX);
    ctrl.shift = (state == sfd_pkg::PH_DATA && in_acc) || out_acc;
    ctrl.tail_data = in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfd_pkg::PH_HUNT;
      fill_count <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      fill_count <= fill_count_next;
      emit_idx <= emit_idx_next;
    end
  end

  `SFD_ASSERT_NOW(a_emit_after_trailer, (out_valid && !$past(out_valid)), ($past(state) == sfd_pkg::PH_TRL2))
  `SFD_ASSERT_NOW(a_fill_only_in_data, (state != sfd_pkg::PH_DATA), (fill_count == '0))
  `SFD_ASSERT_NEXT(a_last_ends_frame, (out_acc && last), (state == sfd_pkg::PH_HUNT))
  `SFD_ASSERT_NOW(a_emit_idx_range, (state == sfd_pkg::PH_EMIT), (emit_idx <= LAST_IDX))
endmodule
`default_nettype wire

FILE: dv/status_frame_deframer_core_tb.sv
// Self-checking testbench of the status frame deframer core with its own frame predictor.
module status_frame_deframer_core_tb;
  import sfd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_BYTES = 40;
  localparam int HOLD_CYCLES = 200;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0] idx;
    logic last;
  } payload_word_t;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_HDR,
    FRM_BAD_TRL1,
    FRM_BAD_TRL2
  } frame_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfd_in_if rx_if ();
  sfd_out_if tx_if ();

  status_frame_deframer_core dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .tx(tx_if)
  );

  phase_t frame_phase;
  logic [5:0] frame_fill;
  byte_t frame_store [PAYLOAD_BYTES];
  payload_word_t pending_words [$];

  int err_cnt = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int frames_emitted = 0;
  int good_frames = 0;
  int broken_frames = 0;
  int idle_cycles = 0;
  int sink_hold_left = 0;
  bit src_gaps_on = 1'b0;
  bit sink_stalls_on = 1'b0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string what, input int expv, input int gotv);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, expv, gotv, $time);
    err_cnt++;
  endtask

  function automatic void track_rx_byte(input byte_t b);
    payload_word_t w;
    case (frame_phase)
      PH_HUNT: begin
        if (b == HDR_FIRST) frame_phase = PH_HDR2;
      end
      PH_HDR2: begin
        if (b == HDR_SECOND) begin
          frame_phase = PH_DATA;
        end else begin
          frame_phase = PH_HUNT;
          frame_fill = '0;
        end
      end
      PH_DATA: begin
        if (frame_fill < PAYLOAD_BYTES) frame_store[frame_fill] = b;
        frame_fill = frame_fill + 6'd1;
        if (frame_fill >= PAYLOAD_BYTES) frame_phase = PH_TRL1;
      end
      PH_TRL1: begin
        if (b == TRL_FIRST) begin
          frame_phase = PH_TRL2;
        end else begin
          frame_phase = PH_HUNT;
          frame_fill = '0;
        end
      end
      PH_TRL2: begin
        if (b == TRL_SECOND) begin
          for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            w.data = frame_store[i];
            w.idx = IDX_W'(i);
            w.last = (i == PAYLOAD_BYTES - 1);
            pending_words = {pending_words, w};
          end
          frames_emitted++;
        end
        frame_phase = PH_HUNT;
        frame_fill = '0;
      end
      default: begin
        frame_phase = PH_HUNT;
        frame_fill = '0;
      end
    endcase
  endfunction

  function automatic byte_t other_than(input byte_t good);
    byte_t b;
    b = byte_t'($urandom);
    while (b == good) b = byte_t'($urandom);
    return b;
  endfunction

  task automatic rx_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      rx_if.valid = 1'b0;
    end
  endtask

  task automatic send_byte(input byte_t b);
    if (src_gaps_on && $urandom_range(0, 5) == 0) rx_gap($urandom_range(1, 5));
    @(negedge clk);
    rx_if.valid = 1'b1;
    rx_if.rx_byte = b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    rx_gap(1);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(input frame_kind_e kind, input bit extremes, input byte_t wrong);
    byte_t b;
    send_byte(HDR_FIRST);
    if (kind == FRM_BAD_HDR) begin
      send_byte(wrong);
      return;
    end
    send_byte(HDR_SECOND);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (!extremes) begin
        b = byte_t'($urandom);
      end else if (i < 8) begin
        b = byte_t'(8'h01 << i);
      end else if (i < 16) begin
        b = ~byte_t'(8'h01 << (i - 8));
      end else begin
        case (i % 4)
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = HDR_FIRST;
          default: b = TRL_SECOND;
        endcase
      end
      send_byte(b);
    end
    if (kind == FRM_BAD_TRL1) begin
      send_byte(wrong);
      send_byte(TRL_SECOND);
      return;
    end
    send_byte(TRL_FIRST);
    send_byte(kind == FRM_BAD_TRL2 ? wrong : TRL_SECOND);
  endtask

  task automatic test_hunting();
    byte_t noise [8] = '{8'h00, 8'hFF, 8'hAA, 8'h54, 8'h56, 8'hD5, 8'h01, 8'h80};
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    foreach (noise[i]) send_byte(noise[i]);
    send_frame(FRM_BAD_HDR, 1'b0, 8'h01);
    send_frame(FRM_BAD_HDR, 1'b0, HDR_FIRST);
    send_byte(HDR_SECOND);
    send_frame(FRM_BAD_HDR, 1'b0, 8'hFF);
    wait_drain();
  endtask

  task automatic test_good_frame();
    send_frame(FRM_GOOD, 1'b1, '0);
    send_byte(TRL_SECOND);
    wait_drain();
  endtask

  task automatic test_broken_trailers();
    send_frame(FRM_BAD_TRL1, 1'b1, TRL_SECOND);
    send_frame(FRM_BAD_TRL2, 1'b1, TRL_FIRST);
    wait_drain();
  endtask

  task automatic test_backpressure();
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    sink_hold_left = HOLD_CYCLES;
    send_frame(FRM_GOOD, 1'b0, '0);
    send_frame(FRM_GOOD, 1'b0, '0);
    wait_drain();
  endtask

  task automatic test_random();
    int start_bytes;
    int pick;
    start_bytes = bytes_sent;
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      repeat ($urandom_range(0, 3)) begin
        send_byte($urandom_range(0, 3) == 0 ? HDR_FIRST : byte_t'($urandom));
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_frame(FRM_GOOD, 1'b0, '0);
        good_frames++;
      end else begin
        if (pick == 7) send_frame(FRM_BAD_HDR, 1'b0, other_than(HDR_SECOND));
        else if (pick == 8) send_frame(FRM_BAD_TRL1, 1'b0, other_than(TRL_FIRST));
        else send_frame(FRM_BAD_TRL2, 1'b0, other_than(TRL_SECOND));
        broken_frames++;
      end
    end
    wait_drain();
  endtask

  task automatic test_closing();
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    send_frame(FRM_GOOD, 1'b0, '0);
    send_frame(FRM_GOOD, 1'b0, '0);
    wait_drain();
  endtask

  initial begin : sink_side
    int n;
    tx_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_left > 0) begin
        tx_if.ready = 1'b0;
        sink_hold_left--;
      end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        tx_if.ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        tx_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_words
    payload_word_t exp_w;
    if (!rst && tx_if.valid && tx_if.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with no frame pending", 0, tx_if.payload_byte);
      end else begin
        exp_w = pending_words.pop_front();
        if (tx_if.payload_byte !== exp_w.data)
          report_mismatch("payload_byte", exp_w.data, tx_if.payload_byte);
        if (tx_if.byte_index !== exp_w.idx)
          report_mismatch("byte_index", exp_w.idx, tx_if.byte_index);
        if (tx_if.last !== exp_w.last)
          report_mismatch("last", exp_w.last, tx_if.last);
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles at %0t", IDLE_LIMIT, $time);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : main
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    frame_phase = PH_HUNT;
    frame_fill = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_hunting();
    test_good_frame();
    test_broken_trailers();
    test_backpressure();
    test_random();
    test_closing();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch("words never delivered", pending_words.size(), 0);

    $display("Covered %0d received bytes, %0d frames emitted, %0d payload words checked.",
             bytes_sent, frames_emitted, words_checked);
    $display("Random part: %0d intact and %0d broken frames; output held off for %0d cycles.",
             good_frames, broken_frames, HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: status_frame_deframer_core.f
+incdir+hw/rtl
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_in_if.sv
hw/rtl/sfd_out_if.sv
hw/rtl/sfd_cell.sv
hw/rtl/sfd_ctrl.sv
hw/rtl/status_frame_deframer_core.sv
dv/status_frame_deframer_core_tb.sv
